// ===== hdl/hfps_pkg.sv =====
// shared types, constants and codes of the five-point heat stencil
package hfps_pkg;

  // grid and value geometry
  localparam int MAX_GRID    = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int COL_W       = $clog2(MAX_GRID);
  localparam int GS_W        = $clog2(MAX_GRID) + 1;
  localparam int ROW_W       = GS_W;

  // step ratio, unsigned fraction
  localparam int RATIO_W     = 30;
  localparam int RATIO_FRAC  = 30;
  localparam int CFG_DATA_W  = RATIO_W;

  // laplacian and product widths
  localparam int LAP_W       = VALUE_BITS + 3;
  localparam int HI_W        = (LAP_W > 32) ? LAP_W - 32 : 1;
  localparam int LO_W        = LAP_W - HI_W;
  localparam int PLO_W       = LO_W + RATIO_W;
  localparam int PHI_W       = HI_W + RATIO_W;
  localparam int PROD_W      = LAP_W + RATIO_W;
  localparam int Q_W         = LAP_W;
  localparam int RES_W       = Q_W + 1;

  // queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FUNC_CELL  = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  typedef enum logic {
    CFG_GRID_SIZE  = 1'b0,
    CFG_STEP_RATIO = 1'b1
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    func_e                         func;
    logic signed [VALUE_BITS-1:0]  cell_value;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  new_value;
    logic                          last_cell;
  } out_beat_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  value;
    logic [COL_W-1:0]              col;
    logic                          left_en;
    logic                          right_en;
    logic                          up_en;
    logic                          emit;
    logic                          last;
  } op_t;

endpackage

// ===== hdl/heat_five_point_stencil.sv =====
// top level of the five-point heat stencil: configuration and assembly
// Streams an n-by-n grid in raster order, one cell per input beat, and gives
// one explicit heat step per cell: (1-4r)*centre + r*(sum of four neighbours),
// neighbours outside the grid taken as zero, values signed Q2.30.
// Input channel: in_valid_i / in_stall_o with in_data_i (func, cell_value).
// After n*n cells send n drain beats to flush the last row; a beat of the
// wrong kind for the current phase is taken and dropped.
// Output channel: out_valid_o / out_stall_i with out_data_o; last_cell marks
// the final cell of the grid. Results trail the input by one row.
// A result is formed once the cell below it is accepted, via the queue, row
// buffer read, laplacian, ratio product and rounding. Throughput: one beat
// per cycle unless stalled, set by the middle row buffer with its two read
// ports and one write port per cycle. A receiver stall on a held result
// freezes the back pipeline; the 4-entry queue then fills and in_stall_o
// rises. No beats are lost or repeated. Reset clears the grid position,
// queue and pipeline; grid_size returns to 1024 and step_ratio to 0. Row
// buffers need no clearing pass. Configuration: cfg_we_i with cfg_index_i
// and cfg_data_i; the user must write when idle, the block never enforces it.
module heat_five_point_stencil (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  hfps_pkg::in_beat_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output hfps_pkg::out_beat_t              out_data_o,
  input  logic                             cfg_we_i,
  input  hfps_pkg::cfg_idx_e               cfg_index_i,
  input  logic [hfps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [hfps_pkg::GS_W-1:0]    grid_size_q;
  logic [hfps_pkg::RATIO_W-1:0] step_ratio_q;
  logic                         push, pop, full, empty;
  hfps_pkg::op_t                op_in, op_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q  <= hfps_pkg::GS_W'(hfps_pkg::MAX_GRID);
      step_ratio_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hfps_pkg::CFG_GRID_SIZE:  grid_size_q  <= cfg_data_i[hfps_pkg::GS_W-1:0];
        hfps_pkg::CFG_STEP_RATIO: step_ratio_q <= cfg_data_i[hfps_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  hfps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .grid_size_i (grid_size_q),
    .full_i      (full),
    .push_o      (push),
    .op_o        (op_in)
  );

  // item queue
  hfps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (op_out)
  );

  // back end
  hfps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .op_i         (op_out),
    .pop_o        (pop),
    .step_ratio_i (step_ratio_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hdl/hfps_front.sv =====
// front end: accepts beats, tracks grid position and classifies items
module hfps_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hfps_pkg::in_beat_t         in_data_i,
  input  logic [hfps_pkg::GS_W-1:0]  grid_size_i,
  input  logic                       full_i,
  output logic                       push_o,
  output hfps_pkg::op_t              op_o
);

  logic [hfps_pkg::COL_W-1:0] col_q, col_d;
  logic [hfps_pkg::ROW_W-1:0] row_q, row_d;
  logic [hfps_pkg::GS_W-1:0]  n;
  logic [hfps_pkg::GS_W-1:0]  col_p1;
  logic                       drain;
  logic                       in_drain_phase;
  logic                       kind_ok;
  logic                       row_end;

  // clamp the grid size into its legal range
  always_comb begin
    if (grid_size_i < hfps_pkg::GS_W'(2)) begin
      n = hfps_pkg::GS_W'(2);
    end else if (grid_size_i > hfps_pkg::GS_W'(hfps_pkg::MAX_GRID)) begin
      n = hfps_pkg::GS_W'(hfps_pkg::MAX_GRID);
    end else begin
      n = grid_size_i;
    end
  end

  // item classification
  assign drain          = (in_data_i.func == hfps_pkg::FUNC_DRAIN);
  assign in_drain_phase = (row_q >= n);
  assign kind_ok        = (drain == in_drain_phase);
  assign col_p1         = {1'b0, col_q} + hfps_pkg::GS_W'(1);
  assign row_end        = (col_p1 >= n);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && kind_ok;

  // item descriptor for the back end
  always_comb begin
    op_o.value    = drain ? '0 : in_data_i.cell_value;
    op_o.col      = col_q;
    op_o.left_en  = (col_q != '0);
    op_o.right_en = !row_end;
    op_o.up_en    = (row_q >= hfps_pkg::ROW_W'(2));
    op_o.emit     = (row_q != '0);
    op_o.last     = drain && row_end;
  end

  // next grid position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        row_d = drain ? '0 : row_q + hfps_pkg::ROW_W'(1);
      end else begin
        col_d = col_p1[hfps_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hdl/hfps_queue.sv =====
// short queue of classified items between front and back
module hfps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hfps_pkg::op_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output hfps_pkg::op_t  data_o
);

  hfps_pkg::op_t               store_q [hfps_pkg::QUEUE_DEPTH];
  logic [hfps_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [hfps_pkg::QCNT_W-1:0] count_q;

  assign full_o  = (count_q == hfps_pkg::QCNT_W'(hfps_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = store_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + hfps_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + hfps_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + hfps_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - hfps_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hfps_pkg::QCNT_W'(hfps_pkg::QUEUE_DEPTH))
    else $error("queue level beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + hfps_pkg::QCNT_W'(1)))
    else $error("queue level did not follow a lone push");
`endif

endmodule

// ===== hdl/hfps_back.sv =====
// back end: row buffers, laplacian, ratio product, rounding and saturation
module hfps_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  hfps_pkg::op_t                 op_i,
  output logic                          pop_o,
  input  logic [hfps_pkg::RATIO_W-1:0]  step_ratio_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hfps_pkg::out_beat_t           out_data_o
);

  localparam logic [hfps_pkg::PROD_W-1:0] RND =
    hfps_pkg::PROD_W'(1) << (hfps_pkg::RATIO_FRAC - 1);

  logic adv, pop;
  logic [hfps_pkg::COL_W-1:0] col_p1;

  // row buffers
  logic signed [hfps_pkg::VALUE_BITS-1:0] middle_row [hfps_pkg::MAX_GRID];
  logic signed [hfps_pkg::VALUE_BITS-1:0] above_row  [hfps_pkg::MAX_GRID];
  logic signed [hfps_pkg::VALUE_BITS-1:0] center_rd_q, right_rd_q, up_rd_q;

  // stage registers
  logic                                   s1_vld_q, s2_vld_q, s3_vld_q;
  hfps_pkg::op_t                          s1_op_q;
  logic signed [hfps_pkg::VALUE_BITS-1:0] win_q;
  logic [hfps_pkg::LAP_W-1:0]             s2_mag_q;
  logic                                   s2_neg_q, s2_emit_q, s2_last_q;
  logic signed [hfps_pkg::VALUE_BITS-1:0] s2_center_q;
  logic [hfps_pkg::PLO_W-1:0]             s3_plo_q;
  logic [hfps_pkg::PHI_W-1:0]             s3_phi_q;
  logic                                   s3_neg_q, s3_emit_q, s3_last_q;
  logic signed [hfps_pkg::VALUE_BITS-1:0] s3_center_q;
  logic                                   out_valid_q;
  hfps_pkg::out_beat_t                    out_q;

  // stage combinational values
  logic signed [hfps_pkg::VALUE_BITS-1:0] left_v, right_v, up_v;
  logic signed [hfps_pkg::LAP_W-1:0]      lap;
  logic [hfps_pkg::LAP_W-1:0]             mag;
  logic [hfps_pkg::PLO_W-1:0]             plo_d;
  logic [hfps_pkg::PHI_W-1:0]             phi_d;
  logic [hfps_pkg::PROD_W-1:0]            full_prod;
  logic [hfps_pkg::Q_W-1:0]               q;
  logic signed [hfps_pkg::RES_W-1:0]      qs, res;
  logic [hfps_pkg::RES_W-hfps_pkg::VALUE_BITS:0] res_top;
  logic signed [hfps_pkg::VALUE_BITS-1:0] sat;

  // whole pipeline moves when the output register can take a beat
  assign adv    = !out_valid_q || !out_stall_i;
  assign pop    = adv && !empty_i;
  assign pop_o  = pop;
  assign col_p1 = op_i.col + hfps_pkg::COL_W'(1);

  // middle row: centre and right reads, then the new cell replaces the centre
  always_ff @(posedge clk_i) begin
    if (pop) begin
      center_rd_q          <= middle_row[op_i.col];
      right_rd_q           <= middle_row[col_p1];
      middle_row[op_i.col] <= op_i.value;
    end
  end

  // above row: read at issue, the old centre is written back from stage s1
  always_ff @(posedge clk_i) begin
    if (pop) begin
      up_rd_q <= above_row[op_i.col];
    end
    if (adv && s1_vld_q) begin
      above_row[s1_op_q.col] <= center_rd_q;
    end
  end

  // laplacian and its magnitude
  always_comb begin
    left_v  = s1_op_q.left_en  ? win_q      : '0;
    right_v = s1_op_q.right_en ? right_rd_q : '0;
    up_v    = s1_op_q.up_en    ? up_rd_q    : '0;
    lap     = hfps_pkg::LAP_W'(left_v) + hfps_pkg::LAP_W'(right_v)
            + hfps_pkg::LAP_W'(up_v) + hfps_pkg::LAP_W'(s1_op_q.value)
            - (hfps_pkg::LAP_W'(center_rd_q) <<< 2);
    mag     = lap[hfps_pkg::LAP_W-1] ? hfps_pkg::LAP_W'(-lap) : hfps_pkg::LAP_W'(lap);
  end

  // ratio product split into low and high partial products
  always_comb begin
    plo_d = s2_mag_q[hfps_pkg::LO_W-1:0] * step_ratio_i;
    phi_d = s2_mag_q[hfps_pkg::LAP_W-1:hfps_pkg::LO_W] * step_ratio_i;
  end

  // recombine, round to nearest with ties away, add centre and saturate
  always_comb begin
    full_prod = (hfps_pkg::PROD_W'(s3_phi_q) << hfps_pkg::LO_W)
              + hfps_pkg::PROD_W'(s3_plo_q) + RND;
    q       = hfps_pkg::Q_W'(full_prod >> hfps_pkg::RATIO_FRAC);
    qs      = $signed({1'b0, q});
    res     = hfps_pkg::RES_W'(s3_center_q) + (s3_neg_q ? -qs : qs);
    res_top = res[hfps_pkg::RES_W-1:hfps_pkg::VALUE_BITS-1];
    if ((&res_top) || !(|res_top)) begin
      sat = res[hfps_pkg::VALUE_BITS-1:0];
    end else if (res[hfps_pkg::RES_W-1]) begin
      sat = {1'b1, {(hfps_pkg::VALUE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(hfps_pkg::VALUE_BITS-1){1'b1}}};
    end
  end

  // stage valids, window register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
    end else if (adv) begin
      s1_vld_q    <= pop;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      out_valid_q <= s3_vld_q && s3_emit_q;
      if (s1_vld_q) begin
        win_q <= center_rd_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q         <= op_i;
      s2_mag_q        <= mag;
      s2_neg_q        <= lap[hfps_pkg::LAP_W-1];
      s2_center_q     <= center_rd_q;
      s2_emit_q       <= s1_op_q.emit;
      s2_last_q       <= s1_op_q.last;
      s3_plo_q        <= plo_d;
      s3_phi_q        <= phi_d;
      s3_neg_q        <= s2_neg_q;
      s3_center_q     <= s2_center_q;
      s3_emit_q       <= s2_emit_q;
      s3_last_q       <= s2_last_q;
      out_q.new_value <= sat;
      out_q.last_cell <= s3_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/heat_five_point_stencil_test.sv =====
// testbench for the five-point heat stencil: self-checking stream regression
`timescale 1ns / 1ps

module heat_five_point_stencil_test;

  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_BEATS  = 600;
  localparam logic signed [hfps_pkg::VALUE_BITS-1:0] TEMP_MAX =
    {1'b0, {(hfps_pkg::VALUE_BITS-1){1'b1}}};
  localparam logic signed [hfps_pkg::VALUE_BITS-1:0] TEMP_MIN =
    {1'b1, {(hfps_pkg::VALUE_BITS-1){1'b0}}};
  localparam logic [hfps_pkg::RATIO_W-1:0] RATIO_HALF =
    hfps_pkg::RATIO_W'(1) << (hfps_pkg::RATIO_FRAC - 1);
  localparam logic [hfps_pkg::RATIO_W-1:0] RATIO_TOP  = '1;

  // clock, reset and block ports
  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  hfps_pkg::in_beat_t              in_beat   = '0;
  logic                            in_stall;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  hfps_pkg::out_beat_t             out_beat;
  logic                            cfg_we    = 1'b0;
  hfps_pkg::cfg_idx_e              cfg_index = hfps_pkg::CFG_GRID_SIZE;
  logic [hfps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor copy of registers and grid state
  logic [hfps_pkg::GS_W-1:0]            grid_size_reg = hfps_pkg::GS_W'(hfps_pkg::MAX_GRID);
  logic [hfps_pkg::RATIO_W-1:0]         ratio_reg     = '0;
  bit signed [hfps_pkg::VALUE_BITS-1:0] above_temps  [hfps_pkg::MAX_GRID];
  bit signed [hfps_pkg::VALUE_BITS-1:0] middle_temps [hfps_pkg::MAX_GRID];
  bit signed [hfps_pkg::VALUE_BITS-1:0] left_temp;
  bit signed [hfps_pkg::VALUE_BITS-1:0] centre_temp;
  int unsigned                          col_pos;
  int unsigned                          row_pos;

  hfps_pkg::out_beat_t expected_cells [$];
  hfps_pkg::in_beat_t  beat_q [$];
  int                  mismatch_count;
  int                  quiet_cycles;
  int                  hold_req;
  bit                  tx_gaps;
  bit                  rx_gaps;

  heat_five_point_stencil dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // effective grid edge after clamping
  function automatic int unsigned grid_n();
    if (grid_size_reg < 2) return 2;
    if (grid_size_reg > hfps_pkg::MAX_GRID) return hfps_pkg::MAX_GRID;
    return int'(grid_size_reg);
  endfunction

  // centre plus rounded r*lap, saturated to the value range
  function automatic logic signed [hfps_pkg::VALUE_BITS-1:0] heat_update(longint centre,
                                                                         longint lap);
    logic [63:0] mag;
    logic [95:0] prod;
    longint      delta;
    longint      sum;
    mag = (lap < 0) ? 64'(-lap) : 64'(lap);
    prod = (96'(mag) * 96'(ratio_reg) + (96'd1 << (hfps_pkg::RATIO_FRAC - 1)))
           >> hfps_pkg::RATIO_FRAC;
    delta = longint'(prod[63:0]);
    if (lap < 0) delta = -delta;
    sum = centre + delta;
    if (sum > longint'(TEMP_MAX)) return TEMP_MAX;
    if (sum < longint'(TEMP_MIN)) return TEMP_MIN;
    return sum[hfps_pkg::VALUE_BITS-1:0];
  endfunction

  // advance the grid state by one accepted beat; returns 1 when a result is due
  function automatic bit step_heat_cell(hfps_pkg::in_beat_t b,
                                        output hfps_pkg::out_beat_t res);
    int unsigned n;
    int unsigned c;
    bit          drain;
    bit          emit;
    longint      v;
    longint      centre;
    longint      left;
    longint      right;
    longint      up;
    n = grid_n();
    drain = (b.func == hfps_pkg::FUNC_DRAIN);
    res = '0;
    emit = 1'b0;
    // wrong kind for the phase: dropped
    if (drain != (row_pos >= n)) return 1'b0;
    c = col_pos;
    v = 0;
    if (!drain) v = longint'(b.cell_value);
    centre = middle_temps[c];
    left_temp = centre_temp;
    centre_temp = middle_temps[c];
    if (row_pos >= 1) begin
      left  = (c > 0) ? longint'(left_temp) : 0;
      right = (c + 1 < n) ? longint'(middle_temps[c + 1]) : 0;
      up    = (row_pos >= 2) ? longint'(above_temps[c]) : 0;
      res.new_value = heat_update(centre, left + right + up + v - 4 * centre);
      res.last_cell = drain && (c + 1 >= n);
      emit = 1'b1;
    end
    above_temps[c] = middle_temps[c];
    middle_temps[c] = v[hfps_pkg::VALUE_BITS-1:0];
    // row end compared with the current size
    if (c + 1 >= n) begin
      col_pos = 0;
      row_pos = drain ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
    return emit;
  endfunction

  function automatic logic signed [hfps_pkg::VALUE_BITS-1:0] pick_temp();
    case ($urandom_range(0, 9))
      0: return TEMP_MAX;
      1: return TEMP_MIN;
      2: return '0;
      3: return hfps_pkg::VALUE_BITS'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [hfps_pkg::RATIO_W-1:0] pick_ratio();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return RATIO_HALF;
      2: return RATIO_TOP;
      default: return hfps_pkg::RATIO_W'($urandom_range(0, RATIO_HALF));
    endcase
  endfunction

  function automatic void add_beat(hfps_pkg::func_e f,
                                   logic signed [hfps_pkg::VALUE_BITS-1:0] v);
    hfps_pkg::in_beat_t b;
    b.func = f;
    b.cell_value = v;
    beat_q.push_back(b);
  endfunction

  // one full grid plus its drain beats, optionally with stray beats of the wrong kind
  function automatic void queue_grid(int n, bit noisy);
    for (int i = 0; i < n * n; i++) begin
      if (noisy && $urandom_range(0, 39) == 0) add_beat(hfps_pkg::FUNC_DRAIN, $urandom);
      add_beat(hfps_pkg::FUNC_CELL, pick_temp());
    end
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) add_beat(hfps_pkg::FUNC_CELL, pick_temp());
      add_beat(hfps_pkg::FUNC_DRAIN, $urandom);
    end
  endfunction

  task automatic write_reg(hfps_pkg::cfg_idx_e idx, logic [hfps_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hfps_pkg::CFG_GRID_SIZE) grid_size_reg = data[hfps_pkg::GS_W-1:0];
    else ratio_reg = data[hfps_pkg::RATIO_W-1:0];
    @(posedge clk);
  endtask

  // drive every queued beat, predicting on acceptance
  task automatic send_beats();
    hfps_pkg::in_beat_t  b;
    hfps_pkg::out_beat_t res;
    while (beat_q.size() != 0) begin
      b = beat_q.pop_front();
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_beat <= b;
      do @(posedge clk); while (in_stall);
      if (step_heat_cell(b, res)) expected_cells.push_back(res);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender pauses until every result is in and the pipeline has gone quiet
  task automatic wait_drained();
    rx_gaps = 1'b0;
    while (expected_cells.size() != 0 || hold_req != 0 || out_stall) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extreme values, clamped small sizes, stray beats, saturation both ways
  task automatic test_corner_values();
    tx_gaps = 1'b1;
    write_reg(hfps_pkg::CFG_GRID_SIZE, 0);
    write_reg(hfps_pkg::CFG_STEP_RATIO, RATIO_HALF);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MIN);
    add_beat(hfps_pkg::FUNC_DRAIN, TEMP_MAX);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MAX);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MAX);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MIN);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MAX);
    add_beat(hfps_pkg::FUNC_DRAIN, '0);
    add_beat(hfps_pkg::FUNC_DRAIN, '1);
    rx_gaps = 1'b1;
    send_beats();
    wait_drained();
    write_reg(hfps_pkg::CFG_GRID_SIZE, 1);
    write_reg(hfps_pkg::CFG_STEP_RATIO, RATIO_TOP);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MAX);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MIN);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MIN);
    add_beat(hfps_pkg::FUNC_CELL, TEMP_MAX);
    add_beat(hfps_pkg::FUNC_DRAIN, TEMP_MIN);
    add_beat(hfps_pkg::FUNC_DRAIN, '0);
    rx_gaps = 1'b1;
    send_beats();
    wait_drained();
  endtask

  // small odd laplacians with r of one half give exact ties
  task automatic test_rounding_ties();
    tx_gaps = 1'b0;
    write_reg(hfps_pkg::CFG_GRID_SIZE, 3);
    write_reg(hfps_pkg::CFG_STEP_RATIO, RATIO_HALF);
    add_beat(hfps_pkg::FUNC_CELL, 1);
    add_beat(hfps_pkg::FUNC_CELL, -3);
    add_beat(hfps_pkg::FUNC_CELL, 0);
    add_beat(hfps_pkg::FUNC_CELL, 5);
    add_beat(hfps_pkg::FUNC_CELL, -1);
    add_beat(hfps_pkg::FUNC_CELL, 2);
    add_beat(hfps_pkg::FUNC_CELL, 0);
    add_beat(hfps_pkg::FUNC_CELL, 7);
    add_beat(hfps_pkg::FUNC_CELL, -2);
    repeat (3) add_beat(hfps_pkg::FUNC_DRAIN, '0);
    rx_gaps = 1'b1;
    send_beats();
    wait_drained();
  endtask

  // a size above range gives full-width rows, then shrink mid-grid into drain
  task automatic test_clamped_grid_size();
    tx_gaps = 1'b1;
    write_reg(hfps_pkg::CFG_GRID_SIZE, hfps_pkg::CFG_DATA_W'(2047));
    write_reg(hfps_pkg::CFG_STEP_RATIO, pick_ratio());
    repeat (hfps_pkg::MAX_GRID) add_beat(hfps_pkg::FUNC_CELL, pick_temp());
    rx_gaps = 1'b1;
    send_beats();
    wait_drained();
    // one full row in, so a size of two gives one short row and then drain
    write_reg(hfps_pkg::CFG_GRID_SIZE, 2);
    repeat (3) add_beat(hfps_pkg::FUNC_CELL, pick_temp());
    repeat (2) add_beat(hfps_pkg::FUNC_DRAIN, $urandom);
    send_beats();
    wait_drained();
  endtask

  // size shrinks while the column count is already past the new row end
  task automatic test_mid_row_resize();
    tx_gaps = 1'b1;
    write_reg(hfps_pkg::CFG_GRID_SIZE, 8);
    write_reg(hfps_pkg::CFG_STEP_RATIO, pick_ratio());
    repeat (21) add_beat(hfps_pkg::FUNC_CELL, pick_temp());
    rx_gaps = 1'b1;
    send_beats();
    wait_drained();
    write_reg(hfps_pkg::CFG_GRID_SIZE, 4);
    repeat (5) add_beat(hfps_pkg::FUNC_CELL, pick_temp());
    repeat (4) add_beat(hfps_pkg::FUNC_DRAIN, $urandom);
    rx_gaps = 1'b1;
    send_beats();
    wait_drained();
  endtask

  // long receiver hold while beats keep coming, so the input side stalls
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    write_reg(hfps_pkg::CFG_GRID_SIZE, 5);
    write_reg(hfps_pkg::CFG_STEP_RATIO, pick_ratio());
    repeat (3) queue_grid(5, 1'b0);
    hold_req = LONG_HOLD;
    send_beats();
    wait_drained();
  endtask

  // random grids and settings; idling stops near the end
  task automatic test_random_grids();
    int                              sent;
    int                              n;
    logic [hfps_pkg::CFG_DATA_W-1:0] size_word;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(17, 24);
        1, 2, 3: n = $urandom_range(9, 16);
        default: n = $urandom_range(2, 8);
      endcase
      size_word = hfps_pkg::CFG_DATA_W'(n);
      if ($urandom_range(0, 3) == 0) begin
        size_word[hfps_pkg::CFG_DATA_W-1:hfps_pkg::GS_W] =
          (hfps_pkg::CFG_DATA_W - hfps_pkg::GS_W)'($urandom);
      end
      write_reg(hfps_pkg::CFG_GRID_SIZE, size_word);
      write_reg(hfps_pkg::CFG_STEP_RATIO, pick_ratio());
      repeat ($urandom_range(1, 3)) queue_grid(n, 1'b1);
      sent += beat_q.size();
      tx_gaps = (sent < RANDOM_BEATS - 300) && ($urandom_range(0, 3) != 0);
      rx_gaps = (sent < RANDOM_BEATS - 300) && ($urandom_range(0, 3) != 0);
      send_beats();
      wait_drained();
    end
  endtask

  // receiver: random stall bursts and the long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result beat with the oldest expected one
  always @(posedge clk) begin
    hfps_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, new_value %h last_cell %b", $time,
                 out_beat.new_value, out_beat.last_cell);
      end else begin
        want = expected_cells.pop_front();
        if (out_beat.new_value !== want.new_value) begin
          mismatch_count++;
          $display("%0t: new_value expected %h, got %h", $time, want.new_value,
                   out_beat.new_value);
        end
        if (out_beat.last_cell !== want.last_cell) begin
          mismatch_count++;
          $display("%0t: last_cell expected %b, got %b", $time, want.last_cell,
                   out_beat.last_cell);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("heat_five_point_stencil regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_values();
    test_rounding_ties();
    test_clamped_grid_size();
    test_mid_row_resize();
    test_backpressure();
    test_random_grids();
    if (mismatch_count == 0) begin
      $display("heat_five_point_stencil regression: pass");
    end else begin
      $display("heat_five_point_stencil regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hfps_pkg.sv
hdl/hfps_front.sv
hdl/hfps_queue.sv
hdl/hfps_back.sv
hdl/heat_five_point_stencil.sv
verif/heat_five_point_stencil_test.sv
